FILE: src/rotate_scale_pixel_sampler_unit_macros.svh
// Assertion helpers, clocked on clk with rst_n as disable.
`ifndef ROTATE_SCALE_PIXEL_SAMPLER_UNIT_MACROS_SVH
`define ROTATE_SCALE_PIXEL_SAMPLER_UNIT_MACROS_SVH

// same-cycle implication
`define RSSU_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RSSU_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/rssu_pkg.sv
`timescale 1ns / 1ps

package rssu_pkg;

  localparam int SRC_PIXELS = 65536;
  localparam int PIXEL_BITS = 16;
  localparam int ADDR_W     = $clog2(SRC_PIXELS);
  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int MAP_STAGES = 8;
  localparam int IN_DATA_W  = 56;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_SRC_WIDTH   = 3'd0,
    REG_SRC_HEIGHT  = 3'd1,
    REG_DST_SIZE    = 3'd2,
    REG_COS_Q       = 3'd3,
    REG_SIN_Q       = 3'd4,
    REG_INV_SCALE_X = 3'd5,
    REG_INV_SCALE_Y = 3'd6,
    REG_TRANSPARENT = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [8:0]  src_width;
    logic [8:0]  src_height;
    logic [9:0]  dst_size;
    logic [15:0] cos_q;
    logic [15:0] sin_q;
    logic [15:0] inv_scale_x;
    logic [15:0] inv_scale_y;
    logic [15:0] transparent_color;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] load_index;
    logic [15:0] pixel_value;
    logic [9:0]  out_x;
    logic [9:0]  out_y;
  } item_t;

  typedef struct packed {
    logic                  vld;
    op_t                   op;
    logic                  wr_ok;
    logic                  outside;
    logic [ADDR_W-1:0]     addr;
    logic [PIXEL_BITS-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic        outside;
    logic [15:0] pixel;
  } result_t;

endpackage

FILE: src/rssu_map.sv
`timescale 1ns / 1ps

module rssu_map (
  input  logic               clk,
  input  logic               rst_n,
  input  rssu_pkg::cfg_t     cfg,
  input  logic               in_vld,
  input  rssu_pkg::item_t    in_item,
  output rssu_pkg::mem_req_t req
);
  import rssu_pkg::*;

  typedef struct packed {
    op_t         op;
    logic [15:0] load_index;
    logic [15:0] pixel_value;
  } carry_t;

  logic [MAP_STAGES-1:0] vld_r;
  carry_t                carry_r [MAP_STAGES];

  // stage 1: center offset
  logic        [8:0]  half;
  logic signed [10:0] tx_nxt, ty_nxt, tx_r, ty_r;
  // stage 2: rotation products
  logic signed [26:0] pxc_r, pys_r, pyc_r, pxs_r;
  // stage 3: rotated offset, Q14
  logic signed [27:0] rx_r, ry_r;
  // stage 4: scaled, Q26
  logic signed [44:0] mx_r, my_r;
  // stage 5: plus source center
  logic signed [45:0] sx_r, sy_r;
  // stage 6: truncate and bounds
  logic               negx, negy, inx, iny;
  logic        [45:0] magx, magy;
  logic        [19:0] qx, qy;
  logic        [8:0]  ox_nxt, oy_nxt, ox_r, oy_r;
  logic               inside_r;
  // stage 7: row offset
  logic        [17:0] prod_r;
  logic        [8:0]  ox7_r;
  logic               inside7_r;
  // stage 8: address
  logic        [17:0] sum;
  logic [ADDR_W-1:0]  addr_nxt, addr_r;
  logic               wr_ok_nxt, wr_ok_r, outside_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[MAP_STAGES-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    carry_r[0] <= '{op: in_item.op, load_index: in_item.load_index,
                    pixel_value: in_item.pixel_value};
    for (int i = 1; i < MAP_STAGES; i++) begin
      carry_r[i] <= carry_r[i-1];
    end
  end

  always_comb begin
    half   = cfg.dst_size[9:1];
    tx_nxt = $signed({1'b0, in_item.out_x}) - $signed({2'b00, half});
    ty_nxt = $signed({1'b0, in_item.out_y}) - $signed({2'b00, half});
  end

  always_comb begin
    negx   = sx_r[45];
    negy   = sy_r[45];
    magx   = negx ? (46'd0 - sx_r) : sx_r;
    magy   = negy ? (46'd0 - sy_r) : sy_r;
    qx     = magx[45:26];
    qy     = magy[45:26];
    // small negative values truncate to zero and stay inside
    inx    = (!negx || qx == 20'd0) && (qx < {11'd0, cfg.src_width});
    iny    = (!negy || qy == 20'd0) && (qy < {11'd0, cfg.src_height});
    ox_nxt = negx ? 9'd0 : qx[8:0];
    oy_nxt = negy ? 9'd0 : qy[8:0];
  end

  always_comb begin
    sum       = {9'd0, ox7_r} + prod_r;
    addr_nxt  = (carry_r[6].op == OP_LOAD) ? ADDR_W'(carry_r[6].load_index) : ADDR_W'(sum);
    wr_ok_nxt = {16'd0, carry_r[6].load_index} < 32'(SRC_PIXELS);
  end

  always_ff @(posedge clk) begin
    tx_r      <= tx_nxt;
    ty_r      <= ty_nxt;
    pxc_r     <= tx_r * $signed(cfg.cos_q);
    pys_r     <= ty_r * $signed(cfg.sin_q);
    pyc_r     <= ty_r * $signed(cfg.cos_q);
    pxs_r     <= tx_r * $signed(cfg.sin_q);
    rx_r      <= $signed({pxc_r[26], pxc_r}) - $signed({pys_r[26], pys_r});
    ry_r      <= $signed({pyc_r[26], pyc_r}) + $signed({pxs_r[26], pxs_r});
    mx_r      <= rx_r * $signed({1'b0, cfg.inv_scale_x});
    my_r      <= ry_r * $signed({1'b0, cfg.inv_scale_y});
    sx_r      <= $signed({mx_r[44], mx_r}) + $signed({12'd0, cfg.src_width, 25'd0});
    sy_r      <= $signed({my_r[44], my_r}) + $signed({12'd0, cfg.src_height, 25'd0});
    ox_r      <= ox_nxt;
    oy_r      <= oy_nxt;
    inside_r  <= inx && iny;
    prod_r    <= oy_r * cfg.src_width;
    ox7_r     <= ox_r;
    inside7_r <= inside_r;
    addr_r    <= addr_nxt;
    wr_ok_r   <= wr_ok_nxt;
    outside_r <= !inside7_r;
  end

  assign req.vld     = vld_r[MAP_STAGES-1];
  assign req.op      = carry_r[MAP_STAGES-1].op;
  assign req.wr_ok   = wr_ok_r;
  assign req.outside = outside_r;
  assign req.addr    = addr_r;
  assign req.wdata   = PIXEL_BITS'(carry_r[MAP_STAGES-1].pixel_value);

endmodule

FILE: src/rotate_scale_pixel_sampler_unit.sv
`timescale 1ns / 1ps
`include "rotate_scale_pixel_sampler_unit_macros.svh"

// Nearest-neighbor rotate/scale sampler over a 64K x 16 source store. Loads
// (tuser = 0) write a source pixel by row-major index; samples (tuser = 1) map
// a destination coordinate back into the source and return one result each.
// Items are taken one per cycle, loads and samples interleaved freely; a
// sample's result enters the result queue after passing the 8-stage
// coordinate pipeline and the store read. Source memory has one write or one
// read per cycle, at the same pipeline position, so a sample always sees every
// earlier load. A 16-entry result queue absorbs output stalls; input ready
// drops only when 16 samples are outstanding. Store contents are undefined
// until loaded; there is no clearing pass. Change registers only while idle.
module rotate_scale_pixel_sampler_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [15:0] load_index, [31:16] pixel_value, [41:32] out_x, [51:42] out_y
  input  logic [rssu_pkg::IN_DATA_W-1:0] in_tdata,
  // [0] opcode
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [15:0] pixel
  output logic [15:0]                    out_tdata,
  // [0] outside
  output logic                           out_tuser,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [4:0]                     cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);
  import rssu_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t reg_idx;
  logic     cfg_wr;

  item_t    item;
  logic     in_acc, samp_acc, out_acc;
  mem_req_t req;

  logic [PIXEL_BITS-1:0] mem [SRC_PIXELS];
  logic [PIXEL_BITS-1:0] rdata_r;
  logic                  mem_we, mem_re;
  logic                  rd_vld_r, rd_outside_r;

  result_t              fifo_r [FIFO_DEPTH];
  result_t              head;
  logic [PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]     fcount_r, fcount_nxt;
  logic [CNT_W-1:0]     pend_r, pend_nxt;

  // configuration
  assign cfg_pready = 1'b1;
  assign reg_idx    = reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{src_width: 9'd256, src_height: 9'd256, dst_size: 10'd256,
                 cos_q: 16'd16384, sin_q: 16'd0, inv_scale_x: 16'd4096,
                 inv_scale_y: 16'd4096, transparent_color: 16'd0};
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SRC_WIDTH:   cfg_r.src_width         <= cfg_pwdata[8:0];
        REG_SRC_HEIGHT:  cfg_r.src_height        <= cfg_pwdata[8:0];
        REG_DST_SIZE:    cfg_r.dst_size          <= cfg_pwdata[9:0];
        REG_COS_Q:       cfg_r.cos_q             <= cfg_pwdata[15:0];
        REG_SIN_Q:       cfg_r.sin_q             <= cfg_pwdata[15:0];
        REG_INV_SCALE_X: cfg_r.inv_scale_x       <= cfg_pwdata[15:0];
        REG_INV_SCALE_Y: cfg_r.inv_scale_y       <= cfg_pwdata[15:0];
        REG_TRANSPARENT: cfg_r.transparent_color <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SRC_WIDTH:   cfg_prdata = {23'd0, cfg_r.src_width};
      REG_SRC_HEIGHT:  cfg_prdata = {23'd0, cfg_r.src_height};
      REG_DST_SIZE:    cfg_prdata = {22'd0, cfg_r.dst_size};
      REG_COS_Q:       cfg_prdata = {16'd0, cfg_r.cos_q};
      REG_SIN_Q:       cfg_prdata = {16'd0, cfg_r.sin_q};
      REG_INV_SCALE_X: cfg_prdata = {16'd0, cfg_r.inv_scale_x};
      REG_INV_SCALE_Y: cfg_prdata = {16'd0, cfg_r.inv_scale_y};
      REG_TRANSPARENT: cfg_prdata = {16'd0, cfg_r.transparent_color};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  // request intake
  assign in_tready = (pend_r != CNT_W'(FIFO_DEPTH));
  assign in_acc    = in_tvalid && in_tready;
  assign samp_acc  = in_acc && (op_t'(in_tuser) == OP_SAMPLE);
  assign out_acc   = out_tvalid && out_tready;

  assign item.op          = op_t'(in_tuser);
  assign item.load_index  = in_tdata[15:0];
  assign item.pixel_value = in_tdata[31:16];
  assign item.out_x       = in_tdata[41:32];
  assign item.out_y       = in_tdata[51:42];

  rssu_map u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_vld  (in_acc),
    .in_item (item),
    .req     (req)
  );

  // source store
  assign mem_we = req.vld && (req.op == OP_LOAD) && req.wr_ok;
  assign mem_re = req.vld && (req.op == OP_SAMPLE) && !req.outside;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[req.addr] <= req.wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= req.vld && (req.op == OP_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    rd_outside_r <= req.outside;
  end

  // result queue
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      fifo_r[wr_ptr_r] <= '{outside: rd_outside_r,
                            pixel: rd_outside_r ? cfg_r.transparent_color : 16'(rdata_r)};
    end
  end

  always_comb begin
    fcount_nxt = fcount_r + CNT_W'(rd_vld_r) - CNT_W'(out_acc);
    pend_nxt   = pend_r + CNT_W'(samp_acc) - CNT_W'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fcount_r <= '0;
      pend_r   <= '0;
    end else begin
      if (rd_vld_r) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      fcount_r <= fcount_nxt;
      pend_r   <= pend_nxt;
    end
  end

  assign head       = fifo_r[rd_ptr_r];
  assign out_tvalid = (fcount_r != '0);
  assign out_tdata  = head.pixel;
  assign out_tuser  = head.outside;

  `RSSU_ASSERT_NOW(a_fifo_no_overflow, rd_vld_r, fcount_r != CNT_W'(FIFO_DEPTH) || out_acc, "result queue overflow")
  `RSSU_ASSERT_NOW(a_queue_within_pending, 1'b1, fcount_r <= pend_r, "queued results exceed outstanding samples")
  `RSSU_ASSERT_NOW(a_outside_is_transparent, out_tvalid && out_tuser, out_tdata == cfg_r.transparent_color, "outside result without transparent color")
  `RSSU_ASSERT_NEXT(a_pending_counts_sample, samp_acc && !out_acc, pend_r == $past(pend_r) + CNT_W'(1), "outstanding count missed a sample")
  `RSSU_ASSERT_NOW(a_no_write_and_read, 1'b1, !(mem_we && mem_re), "store written and read in one cycle")

endmodule
